FILE: design/kmp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// KMP prefix function package
// Shared types and constants for the prefix function block.
// ----------------------------------------------------------------------------
package kmp_pkg;

   localparam int MAX_PATTERN_DEFAULT = 256;
   localparam int SYMBOL_W            = 8;
   localparam int BORDER_W            = 8;

   typedef struct packed {
      logic [SYMBOL_W-1:0] symbol;
      logic                last_symbol;
   } req_type;

   typedef struct packed {
      logic [BORDER_W-1:0] border_length;
      logic                overflow;
      logic                last;
   } rsp_type;

   typedef enum logic {
      KMP_IDLE,
      KMP_CHECK
   } kmp_state_type;

endpackage
`default_nettype wire

FILE: design/kmp_prefix_function.sv
`default_nettype none
// ----------------------------------------------------------------------------
// KMP prefix function
// Computes the prefix-function value of each pattern symbol as it arrives.
// A transaction is taken in the idle state; the check state then falls back
// one border store read per step until the symbol matches. A new one is
// taken once the current one finishes; the check holds while output stalls.
// Fallback steps summed over a pattern never exceed its length.
// Reset clears the sequencer, position and match length; the stores are not.
// ----------------------------------------------------------------------------
module kmp_prefix_function #(
   parameter int MAX_PATTERN = kmp_pkg::MAX_PATTERN_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire kmp_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output kmp_pkg::rsp_type      rsp_data
);
   import kmp_pkg::*;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    out_busy;
   logic    done;
   rsp_type result;

   assign out_busy = rsp_valid_ff && rsp_stall;

   kmp_engine #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .out_busy  (out_busy),
      .done      (done),
      .result    (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

FILE: design/kmp_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// KMP store memory
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module kmp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

FILE: design/kmp_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// KMP prefix engine
// Sequencer that stores the pattern and falls back through stored border
// values, one memory read per step, until the new symbol matches or none is left.
// ----------------------------------------------------------------------------
module kmp_engine #(
   parameter int MAX_PATTERN = kmp_pkg::MAX_PATTERN_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire kmp_pkg::req_type req_data,
   input  wire logic             out_busy,
   output logic                  done,
   output kmp_pkg::rsp_type      result
);
   import kmp_pkg::*;

   localparam int IW = $clog2(MAX_PATTERN);
   localparam int PW = $clog2(MAX_PATTERN + 1);

   kmp_state_type state_ff, state_in;

   logic [PW-1:0]       position_ff, position_in;
   logic [IW-1:0]       match_ff, match_in;
   logic [IW-1:0]       k_ff, k_in;
   logic [SYMBOL_W-1:0] sym_ff, sym_in;
   logic                last_ff, last_in;
   logic                first_ff, first_in;
   logic                ovf_ff, ovf_in;

   logic [SYMBOL_W-1:0] sym_rd;
   logic [IW-1:0]       bor_rd;
   logic [IW-1:0]       sym_addr;
   logic [IW-1:0]       bor_addr;
   logic                mem_wr;
   logic [IW-1:0]       k_final;
   logic [IW-1:0]       step_k;
   logic [31:0]         k_wide;
   logic                accept;
   logic                hit;
   logic                fallback;
   logic                finish;

   assign accept   = (state_ff == KMP_IDLE) && req_valid;
   assign hit      = (sym_rd == sym_ff);
   assign fallback = !first_ff && !ovf_ff && (k_ff != '0) && !hit;
   assign step_k   = (bor_rd < k_ff) ? bor_rd : '0;
   assign k_final  = (first_ff || ovf_ff || !hit) ? '0 : k_ff + IW'(1);
   assign k_wide   = 32'(k_final);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         KMP_IDLE: begin
            if (req_valid) begin
               state_in = KMP_CHECK;
            end
         end
         KMP_CHECK: begin
            if (!fallback && !out_busy) begin
               state_in = KMP_IDLE;
            end
         end
         default: state_in = KMP_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      finish    = 1'b0;
      unique case (state_ff)
         KMP_IDLE:  req_stall = 1'b0;
         KMP_CHECK: finish    = !fallback && !out_busy;
         default:   req_stall = 1'b1;
      endcase
   end

   always_comb begin
      if (state_ff == KMP_IDLE) begin
         sym_addr = match_ff;
      end else if (fallback) begin
         sym_addr = step_k;
      end else begin
         sym_addr = k_ff;
      end
      bor_addr = sym_addr - IW'(1);
   end

   always_comb begin
      position_in = position_ff;
      match_in    = match_ff;
      k_in        = k_ff;
      sym_in      = sym_ff;
      last_in     = last_ff;
      first_in    = first_ff;
      ovf_in      = ovf_ff;
      if (accept) begin
         sym_in   = req_data.symbol;
         last_in  = req_data.last_symbol;
         first_in = (position_ff == '0);
         ovf_in   = (position_ff == PW'(MAX_PATTERN));
         k_in     = match_ff;
      end else if (state_ff == KMP_CHECK && fallback) begin
         k_in = step_k;
      end
      if (finish) begin
         if (!ovf_ff) begin
            position_in = position_ff + PW'(1);
            match_in    = k_final;
         end
         if (last_ff) begin
            position_in = '0;
            match_in    = '0;
         end
      end
   end

   assign mem_wr = finish && !ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= KMP_IDLE;
         position_ff <= '0;
         match_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         position_ff <= position_in;
         match_ff    <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff     <= k_in;
      sym_ff   <= sym_in;
      last_ff  <= last_in;
      first_ff <= first_in;
      ovf_ff   <= ovf_in;
   end

   kmp_ram #(
      .WIDTH (SYMBOL_W),
      .DEPTH (MAX_PATTERN),
      .AW    (IW)
   ) u_symbol_store (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (position_ff[IW-1:0]),
      .wr_data (sym_ff),
      .rd_addr (sym_addr),
      .rd_data (sym_rd)
   );

   kmp_ram #(
      .WIDTH (IW),
      .DEPTH (MAX_PATTERN),
      .AW    (IW)
   ) u_border_store (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (position_ff[IW-1:0]),
      .wr_data (k_final),
      .rd_addr (bor_addr),
      .rd_data (bor_rd)
   );

   assign done                 = finish;
   assign result.border_length = (k_wide > 32'd255) ? 8'hFF : k_wide[7:0];
   assign result.overflow      = ovf_ff;
   assign result.last          = last_ff;

endmodule
`default_nettype wire
